FILE: rtl/core/kdslp_pkg.sv
// Package with shared types and constants for the key debounce block.
package kdslp_pkg;

    // Default number of keys with state storage.
    localparam int KEY_COUNT_DEF = 2;

    // Tick counters stop counting at this value.
    localparam logic [15:0] TICK_SAT = 16'hFFF0;

    // Configuration register reset values.
    localparam logic [15:0] FILTER_TICKS_RST = 16'd2;
    localparam logic [15:0] LONG_TICKS_RST   = 16'd100;
    localparam logic        PRESS_KIND_RST   = 1'b1;

    // Configuration address decode: word index taken from paddr[3:2].
    localparam int          CFG_ADDR_W     = 4;
    localparam logic [1:0]  REG_FILTER     = 2'd0;
    localparam logic [1:0]  REG_LONG       = 2'd1;
    localparam logic [1:0]  REG_PRESS_KIND = 2'd2;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // One entry of the per-key state memory.
    typedef struct packed {
        logic [15:0] released_ticks;
        logic [15:0] pressed_ticks;
        logic        released_flag;
        logic        pressed_flag;
        logic        long_armed;
    } key_state_t;

    // Value of an entry that has not been written since reset.
    localparam key_state_t KEY_STATE_RST = '{
        released_ticks: 16'd0,
        pressed_ticks:  16'd0,
        released_flag:  1'b0,
        pressed_flag:   1'b0,
        long_armed:     1'b1
    };

endpackage

FILE: rtl/core/key_debounce_short_long_press.sv
// Top level of the key debouncer with short-press and long-press detection.
//
// Usage: each transfer on the s_ channel is one scan tick for one key, with
// the key number in s_tdata[0] and the raw pin level in s_tdata[1] (1 means
// released). For every accepted tick the block returns exactly one result on
// the m_ channel: key number, debounced released and pressed flags, and
// one-tick short-press and long-press pulses.
// Path: an accepted tick enters the update stage with the state read for its
// key; the update stage writes the state back and loads the output register.
// Throughput: one tick per cycle while the receiver keeps up. The rate is set
// by the read-modify-write loop on the per-key state memory; a bypass register
// forwards a write to a read of the same key at the same edge, so consecutive
// ticks for one key also go back to back. When the receiver stalls, the result
// holds in the output register and one more tick may wait in the update stage;
// s_tready drops only when both are full. Reset clears the control state, the
// per-key valid bits (unwritten keys read as their reset state) and the
// configuration registers to their defaults. The user writes registers over
// the APB port only while the block is idle; the block does not enforce it.
module key_debounce_short_long_press
    import kdslp_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Scan tick input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0: key_index, pin_high, zero padding.
    input  logic [S_DATA_W-1:0]   s_tdata,
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0: key_number, released_stable, pressed_stable,
    // short_press, long_press, zero padding.
    output logic [M_DATA_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int  KEY_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic ONE_KEY = (KEY_COUNT == 1);

    // Configuration registers.
    logic [15:0] filter_ticks_reg;
    logic [15:0] long_ticks_reg;
    logic        press_kind_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // State memory and its valid bits.
    key_state_t     state_mem [KEY_COUNT];
    key_state_t     mem_q_reg;
    logic [KEY_COUNT-1:0] entry_valid_reg;

    // Update stage.
    logic        s1_valid_reg;
    logic        s1_key_reg;
    logic        s1_pin_reg;
    logic        s1_range_reg;
    logic        s1_fwd_reg;
    logic        s1_entry_valid_reg;
    key_state_t  fwd_data_reg;

    // Output register.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic              s_accept;
    logic              s1_advance;
    logic [KEY_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  wr_addr;
    logic              wr_en;
    logic              in_range;
    key_state_t        cur_state;
    key_state_t        state_next;
    logic              short_pulse;
    logic              long_pulse;
    logic [15:0]       released_inc;
    logic [15:0]       pressed_inc;
    logic [M_DATA_W-1:0] out_data_next;

    // Configuration write decode and read mux.
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_ticks_reg <= FILTER_TICKS_RST;
            long_ticks_reg   <= LONG_TICKS_RST;
            press_kind_reg   <= PRESS_KIND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER:     filter_ticks_reg <= pwdata[15:0];
                REG_LONG:       long_ticks_reg   <= pwdata[15:0];
                REG_PRESS_KIND: press_kind_reg   <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_FILTER:     prdata = {16'd0, filter_ticks_reg};
            REG_LONG:       prdata = {16'd0, long_ticks_reg};
            REG_PRESS_KIND: prdata = {31'd0, press_kind_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Handshake: the update stage moves on when the output register is free.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    assign rd_addr  = KEY_W'(s_tdata[0]);
    assign wr_addr  = KEY_W'(s1_key_reg);
    assign wr_en    = s1_advance && s1_range_reg;
    assign in_range = !(ONE_KEY && s_tdata[0]);

    // State memory: registered read on accept, write back from the update stage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= state_next;
        end
        if (s_accept)
        begin
            mem_q_reg <= state_mem[rd_addr];
        end
    end

    // Valid bits mark entries written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Update stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Update stage payload, with the bypass for a write to the key being read.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_key_reg         <= s_tdata[0];
            s1_pin_reg         <= s_tdata[1];
            s1_range_reg       <= in_range;
            s1_entry_valid_reg <= entry_valid_reg[rd_addr];
            s1_fwd_reg         <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg       <= state_next;
        end
    end

    // Current state of the key: bypass, memory, or reset value.
    always_comb
    begin
        priority if (s1_fwd_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (s1_entry_valid_reg)
        begin
            cur_state = mem_q_reg;
        end
        else
        begin
            cur_state = KEY_STATE_RST;
        end
    end

    assign released_inc = (cur_state.released_ticks < TICK_SAT) ?
                          cur_state.released_ticks + 16'd1 : cur_state.released_ticks;
    assign pressed_inc  = (cur_state.pressed_ticks < TICK_SAT) ?
                          cur_state.pressed_ticks + 16'd1 : cur_state.pressed_ticks;

    // Debounce and press classification for one tick.
    always_comb
    begin
        state_next  = cur_state;
        short_pulse = 1'b0;
        long_pulse  = 1'b0;
        if (s1_pin_reg)
        begin
            // Released tick: a debounced press ends here.
            if (press_kind_reg)
            begin
                if (cur_state.pressed_flag)
                begin
                    if ((cur_state.pressed_ticks != 16'd0) &&
                        (cur_state.pressed_ticks < long_ticks_reg))
                    begin
                        short_pulse = 1'b1;
                    end
                    else if ((cur_state.pressed_ticks >= long_ticks_reg) &&
                             cur_state.long_armed)
                    begin
                        long_pulse = 1'b1;
                    end
                end
                state_next.long_armed = 1'b1;
            end
            state_next.pressed_ticks  = 16'd0;
            state_next.released_ticks = released_inc;
            if (released_inc > filter_ticks_reg)
            begin
                state_next.released_flag = 1'b1;
                state_next.pressed_flag  = 1'b0;
            end
        end
        else
        begin
            // Pressed tick: count the hold and watch for a long press.
            state_next.released_ticks = 16'd0;
            state_next.pressed_ticks  = pressed_inc;
            if (pressed_inc > filter_ticks_reg)
            begin
                state_next.pressed_flag  = 1'b1;
                state_next.released_flag = 1'b0;
            end
            if (press_kind_reg && cur_state.long_armed && (pressed_inc > long_ticks_reg))
            begin
                long_pulse            = 1'b1;
                state_next.long_armed = 1'b0;
            end
        end
    end

    // Result packing; a key without storage reports only its number.
    always_comb
    begin
        if (s1_range_reg)
        begin
            out_data_next = {3'd0, long_pulse, short_pulse, state_next.pressed_flag,
                             state_next.released_flag, s1_key_reg};
        end
        else
        begin
            out_data_next = {7'd0, s1_key_reg};
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: sim/kdslp_checker.sv
// Checker for the key debouncer: tracks register writes, predicts each result and compares.
module kdslp_checker
    import kdslp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata fields from bit 0: key_index, pin_high, zero padding.
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0: key_number, released_stable, pressed_stable,
    // short_press, long_press, zero padding.
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    error_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result transfer, last field in the lowest bit.
    typedef struct packed {
        logic long_press;
        logic short_press;
        logic pressed_stable;
        logic released_stable;
        logic key_number;
    } tick_result_t;

    // Shadow copy of the configuration registers.
    logic [15:0] filter_ticks;
    logic [15:0] long_ticks;
    logic        kind_en;

    // Shadow copy of the per-key debounce state.
    logic [15:0] rel_cnt      [KEY_COUNT_DEF];
    logic [15:0] press_cnt    [KEY_COUNT_DEF];
    logic        rel_stable   [KEY_COUNT_DEF];
    logic        press_stable [KEY_COUNT_DEF];
    logic        long_armed   [KEY_COUNT_DEF];

    // Results predicted for ticks already accepted, oldest first.
    tick_result_t expected_results [$];

    // Advances the state of one key by one scan tick and returns its result.
    function automatic tick_result_t debounce_tick(logic key, logic pin_high);
        tick_result_t r;
        int k;
        r = '0;
        r.key_number = key;
        k = int'(key);
        if (k >= KEY_COUNT_DEF)
        begin
            return r;
        end
        if (pin_high)
        begin
            // A release ends a debounced press: short or long depending on its length.
            if (kind_en)
            begin
                if (press_stable[k])
                begin
                    if (press_cnt[k] != 16'd0 && press_cnt[k] < long_ticks)
                        r.short_press = 1'b1;
                    else if (press_cnt[k] >= long_ticks && long_armed[k])
                        r.long_press = 1'b1;
                end
                long_armed[k] = 1'b1;
            end
            press_cnt[k] = 16'd0;
            if (rel_cnt[k] < TICK_SAT)
                rel_cnt[k] = rel_cnt[k] + 16'd1;
            if (rel_cnt[k] > filter_ticks)
            begin
                rel_stable[k] = 1'b1;
                press_stable[k] = 1'b0;
            end
        end
        else
        begin
            rel_cnt[k] = 16'd0;
            if (press_cnt[k] < TICK_SAT)
                press_cnt[k] = press_cnt[k] + 16'd1;
            if (press_cnt[k] > filter_ticks)
            begin
                press_stable[k] = 1'b1;
                rel_stable[k] = 1'b0;
            end
            // A hold past the long threshold fires once until the next release.
            if (kind_en && long_armed[k] && press_cnt[k] > long_ticks)
            begin
                r.long_press = 1'b1;
                long_armed[k] = 1'b0;
            end
        end
        r.released_stable = rel_stable[k];
        r.pressed_stable = press_stable[k];
        return r;
    endfunction

    // Counts a failure and reports only the first ten.
    task automatic note_failure(string what, logic [7:0] want, logic [7:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Watch both channels and the register port at every edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_result_t want;
        logic [7:0] got;
        if (!rst_n)
        begin
            filter_ticks = FILTER_TICKS_RST;
            long_ticks = LONG_TICKS_RST;
            kind_en = PRESS_KIND_RST;
            for (int k = 0; k < KEY_COUNT_DEF; k++)
            begin
                rel_cnt[k] = 16'd0;
                press_cnt[k] = 16'd0;
                rel_stable[k] = 1'b0;
                press_stable[k] = 1'b0;
                long_armed[k] = 1'b1;
            end
            expected_results.delete();
            error_count = 0;
            pending <= 0;
        end
        else
        begin
            // Register writes land on the access cycle.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FILTER:     filter_ticks = pwdata[15:0];
                    REG_LONG:       long_ticks = pwdata[15:0];
                    REG_PRESS_KIND: kind_en = pwdata[0];
                    default:        ;
                endcase
            end

            // Every accepted scan tick yields exactly one result.
            if (s_tvalid && s_tready)
                expected_results.push_back(debounce_tick(s_tdata[0], s_tdata[1]));

            // Compare each result transfer with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    note_failure("unexpected result", 8'h00, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got[0] !== want.key_number)
                        note_failure("key_number", {7'd0, want.key_number}, {7'd0, got[0]});
                    if (got[1] !== want.released_stable)
                        note_failure("released_stable", {7'd0, want.released_stable},
                                     {7'd0, got[1]});
                    if (got[2] !== want.pressed_stable)
                        note_failure("pressed_stable", {7'd0, want.pressed_stable},
                                     {7'd0, got[2]});
                    if (got[3] !== want.short_press)
                        note_failure("short_press", {7'd0, want.short_press}, {7'd0, got[3]});
                    if (got[4] !== want.long_press)
                        note_failure("long_press", {7'd0, want.long_press}, {7'd0, got[4]});
                    if (got[7:5] !== 3'b000)
                        note_failure("padding", 8'h00, {5'd0, got[7:5]});
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the key debouncer: clock, reset, stimulus, stalls and verdict.
module tb_top
    import kdslp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata fields from bit 0: key_index, pin_high, zero padding.
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata fields from bit 0: key_number, released_stable, pressed_stable,
    // short_press, long_press, zero padding.
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int error_count;
    int pending;

    // Stimulus controls shared with the receiver process.
    logic       no_idle = 1'b0;
    logic [7:0] hold_req = '0;
    logic [7:0] hold_done = '0;
    int         hold_left = 0;
    int         stall_cycles = 0;

    // Current settings and per-key press pattern of the generator.
    int   cfg_filter = 2;
    int   cfg_long = 100;
    logic lvl [2] = '{1'b1, 1'b1};
    int   run_left [2] = '{0, 0};

    key_debounce_short_long_press uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    kdslp_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (error_count),
        .pending     (pending)
    );

    always #2 clk = ~clk;

    // Receiver: random stalls, quiet stretches and a long counted hold-off.
    always @(posedge clk)
    begin
        if (hold_req != hold_done)
        begin
            hold_done <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (no_idle)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= 14);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offers one scan tick, after an occasional gap, and waits for its transfer.
    task automatic send_tick(logic key, logic pin);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 6)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b000000, pin, key};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic hold_pin(logic key, logic pin, int count);
        for (int i = 0; i < count; i++)
            send_tick(key, pin);
    endtask

    // Stops offering ticks and waits until every result is back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(int filter, int long_t, int en);
        wait_drained();
        write_reg(REG_FILTER, filter);
        write_reg(REG_LONG, long_t);
        write_reg(REG_PRESS_KIND, en);
        cfg_filter = filter;
        cfg_long = long_t;
    endtask

    // Picks how long a key keeps one level: bounces, near the filter, near the
    // long threshold, or anything up to both combined plus four, at most 300.
    function automatic int pick_run();
        int lim;
        int base;
        int lo;
        lim = cfg_filter + cfg_long + 4;
        if (lim > 300)
            lim = 300;
        case ($urandom_range(3))
            0: return $urandom_range(1, 3);
            1: return $urandom_range(1, lim);
            2:
            begin
                base = (cfg_long > 298) ? 298 : cfg_long;
                lo = (base > 1) ? base - 1 : 1;
                return $urandom_range(lo, base + 2);
            end
            default:
            begin
                base = (cfg_filter > 296) ? 296 : cfg_filter;
                lo = (base > 0) ? base : 1;
                return $urandom_range(lo, base + 2);
            end
        endcase
    endfunction

    // Two keys pressed and released in interleaved runs, with some pin noise.
    task automatic run_random(int n_items);
        int key;
        logic pin;
        for (int i = 0; i < n_items; i++)
        begin
            key = $urandom_range(1);
            if (run_left[key] == 0)
            begin
                lvl[key] = ~lvl[key];
                run_left[key] = pick_run();
            end
            pin = lvl[key];
            if ($urandom_range(99) < 6)
                pin = ~pin;
            run_left[key] = run_left[key] - 1;
            send_tick(key[0], pin);
        end
    endtask

    // Main sequence of phases.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a short press on key 0, then bouncing on key 1.
        hold_pin(1'b0, 1'b0, 4);
        hold_pin(1'b0, 1'b1, 3);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        run_random(300);

        // Long threshold of zero: a second release tick with the press still stable fires.
        configure(2, 0, 1);
        hold_pin(1'b1, 1'b0, 4);
        hold_pin(1'b1, 1'b1, 2);
        run_random(120);

        // Detection disabled.
        configure(2, 5, 0);
        hold_pin(1'b0, 1'b0, 6);
        hold_pin(1'b0, 1'b1, 2);
        run_random(120);

        configure(0, 1, 1);
        run_random(150);

        // Receiver holds off while the sender keeps offering, so the input stalls.
        configure(1, 5, 1);
        run_random(100);
        no_idle <= 1'b1;
        hold_req <= hold_req + 8'd1;
        run_random(80);
        no_idle <= 1'b0;

        // A stretch with no idling on either side, then a full pause.
        configure(4, 20, 1);
        no_idle <= 1'b1;
        run_random(200);
        no_idle <= 1'b0;
        wait_drained();
        run_random(150);

        // Largest thresholds: nothing ever becomes stable.
        configure(65535, 65535, 1);
        run_random(100);

        configure($urandom_range(0, 6), $urandom_range(1, 40), $urandom_range(1));
        run_random(100);
        configure($urandom_range(0, 6), $urandom_range(1, 40), $urandom_range(1));
        run_random(100);

        // Long threshold at the counter limit: a hold never reaches it, a release is short.
        configure(3, 16'hFFF0, 1);
        hold_pin(1'b0, 1'b0, 40);
        hold_pin(1'b0, 1'b1, 4);
        run_random(50);

        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
